// ===== hdl/cft_pkg.sv =====
// package for the conflating fan-out table
// types, codes and sizes shared by the engine, the counters and the top level
package cft_pkg;

   localparam int SUBSCRIBERS  = 8;
   localparam int TOPICS       = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int COUNTER_BITS = 48;
   localparam int SUB_BITS     = $clog2(SUBSCRIBERS);
   localparam int TOPIC_BITS   = $clog2(TOPICS);
   localparam int CELLS        = SUBSCRIBERS * TOPICS;
   localparam int CELL_BITS    = $clog2(CELLS);
   localparam int LEN_BITS     = TOPIC_BITS + 1;
   localparam int CNT_FIELD    = 4;
   localparam int NUM_COUNTERS = 7;
   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic [2:0] {
      CMD_PUBLISH   = 3'd0,
      CMD_SUBSCRIBE = 3'd1,
      CMD_GRANT     = 3'd2,
      CMD_REVOKE    = 3'd3,
      CMD_DRAIN     = 3'd4,
      CMD_ADD_SUB   = 3'd5,
      CMD_READ_CNT  = 3'd6,
      CMD_NONE      = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      RS_OK      = 3'd0,
      RS_BAD_SUB = 3'd1,
      RS_STOPPED = 3'd2,
      RS_DENIED  = 3'd3,
      RS_FULL    = 3'd4,
      RS_UPDATE  = 3'd5
   } res_status_type;

   typedef enum logic [2:0] {
      CNT_PUBLISHED   = 3'd0,
      CNT_QUEUED      = 3'd1,
      CNT_DENIED      = 3'd2,
      CNT_WITHHELD    = 3'd3,
      CNT_REVOCATIONS = 3'd4,
      CNT_DELIVERED   = 3'd5,
      CNT_CONFLATED   = 3'd6
   } cnt_sel_type;

   typedef enum logic {
      REG_OPEN = 1'b0,
      REG_STOP = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [2:0]              command;
      logic [SUB_BITS-1:0]     subscriber;
      logic [TOPIC_BITS-1:0]   topic;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [2:0]              counter_select;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [SUB_BITS-1:0]     out_subscriber;
      logic [TOPIC_BITS-1:0]   out_topic;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic [COUNTER_BITS-1:0] count_value;
      logic                    last;
   } rsp_type;

   // one entry per subscriber and topic
   typedef struct packed {
      logic                    roster;
      logic                    entitled;
      logic                    slot_valid;
      logic [PAYLOAD_BITS-1:0] value;
   } cell_type;

   typedef struct packed {
      logic                en;
      cnt_sel_type         sel;
      logic [LEN_BITS-1:0] amount;
   } stat_bump_type;

endpackage

// ===== hdl/conflating_fanout_table.sv =====
// conflating fan-out table: one command at a time, state in three rams
// a publish reads the cell of every subscriber and searches the pending list of each
// one whose slot is already pending; a drain walks the pending list entry by entry
// a new command word is taken only once the engine is back in idle
// reset: synchronous; a clearing pass over all 512 cells of the cell ram follows reset,
// during which input words are stalled (register writes are still taken)
module conflating_fanout_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cft_pkg::req_type                    req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cft_pkg::rsp_type                    rsp_word,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cft_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import cft_pkg::*;

   logic                    open_ff, stop_ff;
   logic                    cache_we, cache_re, cell_we, cell_re, order_we, order_re;
   logic [TOPIC_BITS-1:0]   cache_waddr, cache_raddr;
   logic [PAYLOAD_BITS-1:0] cache_wdata, cache_rdata;
   logic [CELL_BITS-1:0]    cell_waddr, cell_raddr, order_waddr, order_raddr;
   cell_type                cell_wdata, cell_rdata;
   logic [TOPIC_BITS-1:0]   order_wdata, order_rdata;
   stat_bump_type           bump;
   logic [2:0]              stat_sel;
   logic [COUNTER_BITS-1:0] stat_value;
   logic                    csr_wr;
   csr_reg_type             csr_reg;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b1;
         stop_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_reg)
            REG_OPEN: open_ff <= csr_pwdata[0];
            REG_STOP: stop_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   assign csr_prdata = {31'd0, (csr_reg == REG_STOP) ? stop_ff : open_ff};

   cft_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .open_mode   (open_ff),
      .stopped     (stop_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .cache_we    (cache_we),
      .cache_waddr (cache_waddr),
      .cache_wdata (cache_wdata),
      .cache_re    (cache_re),
      .cache_raddr (cache_raddr),
      .cache_rdata (cache_rdata),
      .cell_we     (cell_we),
      .cell_waddr  (cell_waddr),
      .cell_wdata  (cell_wdata),
      .cell_re     (cell_re),
      .cell_raddr  (cell_raddr),
      .cell_rdata  (cell_rdata),
      .order_we    (order_we),
      .order_waddr (order_waddr),
      .order_wdata (order_wdata),
      .order_re    (order_re),
      .order_raddr (order_raddr),
      .order_rdata (order_rdata),
      .bump        (bump),
      .stat_sel    (stat_sel),
      .stat_value  (stat_value)
   );

   cft_stats u_stats (
      .clock    (clock),
      .reset    (reset),
      .bump     (bump),
      .rd_sel   (stat_sel),
      .rd_value (stat_value)
   );

   cft_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(TOPICS)) u_cache_ram (
      .clock   (clock),
      .wr_en   (cache_we),
      .wr_addr (cache_waddr),
      .wr_data (cache_wdata),
      .rd_en   (cache_re),
      .rd_addr (cache_raddr),
      .rd_data (cache_rdata)
   );

   cft_ram #(.WIDTH($bits(cell_type)), .DEPTH(CELLS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_en   (cell_re),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   cft_ram #(.WIDTH(TOPIC_BITS), .DEPTH(CELLS)) u_order_ram (
      .clock   (clock),
      .wr_en   (order_we),
      .wr_addr (order_waddr),
      .wr_data (order_wdata),
      .rd_en   (order_re),
      .rd_addr (order_raddr),
      .rd_data (order_rdata)
   );

endmodule

// ===== hdl/cft_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cft_stats.sv =====
// saturating statistics counters with a read mux
// depends on cft_pkg
module cft_stats (
   input  logic                           clock,
   input  logic                           reset,
   input  cft_pkg::stat_bump_type         bump,
   input  logic [2:0]                     rd_sel,
   output logic [cft_pkg::COUNTER_BITS-1:0] rd_value
);
   import cft_pkg::*;

   logic [COUNTER_BITS-1:0] cnt_ff [NUM_COUNTERS];
   logic [COUNTER_BITS-1:0] cnt_in [NUM_COUNTERS];
   logic [COUNTER_BITS:0]   sum;
   logic [COUNTER_BITS-1:0] cur;

   always_comb begin
      cnt_in = cnt_ff;
      cur    = cnt_ff[bump.sel];
      sum    = {1'b0, cur} + (COUNTER_BITS+1)'(bump.amount);
      if (bump.en) begin
         // carry out means the counter sticks at all ones
         cnt_in[bump.sel] = sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rd_value = (rd_sel < 3'(NUM_COUNTERS)) ? cnt_ff[rd_sel] : '0;

endmodule

// ===== hdl/cft_engine.sv =====
// command sequencer: reads, modifies and writes back the cell, cache and
// pending-order memories; depends on cft_pkg
module cft_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              open_mode,
   input  logic                              stopped,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cft_pkg::req_type                  req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cft_pkg::rsp_type                  rsp_word,
   output logic                              cache_we,
   output logic [cft_pkg::TOPIC_BITS-1:0]    cache_waddr,
   output logic [cft_pkg::PAYLOAD_BITS-1:0]  cache_wdata,
   output logic                              cache_re,
   output logic [cft_pkg::TOPIC_BITS-1:0]    cache_raddr,
   input  logic [cft_pkg::PAYLOAD_BITS-1:0]  cache_rdata,
   output logic                              cell_we,
   output logic [cft_pkg::CELL_BITS-1:0]     cell_waddr,
   output cft_pkg::cell_type                 cell_wdata,
   output logic                              cell_re,
   output logic [cft_pkg::CELL_BITS-1:0]     cell_raddr,
   input  cft_pkg::cell_type                 cell_rdata,
   output logic                              order_we,
   output logic [cft_pkg::CELL_BITS-1:0]     order_waddr,
   output logic [cft_pkg::TOPIC_BITS-1:0]    order_wdata,
   output logic                              order_re,
   output logic [cft_pkg::CELL_BITS-1:0]     order_raddr,
   input  logic [cft_pkg::TOPIC_BITS-1:0]    order_rdata,
   output cft_pkg::stat_bump_type            bump,
   output logic [2:0]                        stat_sel,
   input  logic [cft_pkg::COUNTER_BITS-1:0]  stat_value
);
   import cft_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_EMIT,
      ST_PUB_RD, ST_PUB_CHK, ST_PUB_NEXT,
      ST_SRCH_RD, ST_SRCH_CK, ST_APPEND,
      ST_SUB_CHK, ST_SUB_OK, ST_GRANT_WR,
      ST_REV_WR, ST_REV_WH, ST_REV_RD, ST_REV_CK,
      ST_DR_RD, ST_DR_CELL, ST_DR_CK, ST_DR_END
   } state_type;

   state_type               state_ff, state_in, ret_ff, ret_in;
   req_type                 req_ff, req_in;
   rsp_type                 res_ff, res_in, hold_ff, hold_in, rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SUB_BITS-1:0]     u_ff, u_in, pl_ff, pl_in;
   logic [CNT_FIELD-1:0]    qcnt_ff, qcnt_in, scount_ff, scount_in;
   logic [LEN_BITS-1:0]     idx_ff, idx_in, j_ff, j_in, k_ff, k_in;
   logic [LEN_BITS-1:0]     len_ff [SUBSCRIBERS];
   logic [LEN_BITS-1:0]     len_in [SUBSCRIBERS];
   logic [TOPICS-1:0]       cvalid_ff, cvalid_in;
   logic                    was_ff, was_in;
   logic [TOPIC_BITS-1:0]   v_ff, v_in;
   logic [CELL_BITS-1:0]    clr_ff, clr_in;
   logic                    out_free, known;
   logic [SUB_BITS-1:0]     s;
   logic [TOPIC_BITS-1:0]   t;

   function automatic rsp_type make_res(input res_status_type st,
                                        input logic [SUB_BITS-1:0] sub,
                                        input logic [TOPIC_BITS-1:0] top,
                                        input logic [PAYLOAD_BITS-1:0] pay,
                                        input logic [COUNTER_BITS-1:0] cnt,
                                        input logic lst);
      rsp_type r;
      r.status         = st;
      r.out_subscriber = sub;
      r.out_topic      = top;
      r.out_payload    = pay;
      r.count_value    = cnt;
      r.last           = lst;
      return r;
   endfunction

   assign s        = req_ff.subscriber;
   assign t        = req_ff.topic;
   assign known    = {1'b0, s} < scount_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign stat_sel = req_ff.counter_select;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      u_in         = u_ff;
      pl_in        = pl_ff;
      qcnt_in      = qcnt_ff;
      scount_in    = scount_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      len_in       = len_ff;
      cvalid_in    = cvalid_ff;
      was_in       = was_ff;
      v_in         = v_ff;
      clr_in       = clr_ff;
      cache_we     = 1'b0;
      cache_waddr  = t;
      cache_wdata  = req_ff.payload;
      cache_re     = 1'b0;
      cache_raddr  = t;
      cell_we      = 1'b0;
      cell_waddr   = {s, t};
      cell_wdata   = cell_rdata;
      cell_re      = 1'b0;
      cell_raddr   = {s, t};
      order_we     = 1'b0;
      order_waddr  = {s, j_ff[TOPIC_BITS-1:0]};
      order_wdata  = order_rdata;
      order_re     = 1'b0;
      order_raddr  = {s, idx_ff[TOPIC_BITS-1:0]};
      bump         = '0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the cell memory once after reset
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
            cell_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EMIT;
            res_in   = make_res(RS_OK, s, t, '0, '0, 1'b1);
            case (req_ff.command)
               CMD_PUBLISH: begin
                  if (stopped) begin
                     res_in.status = RS_STOPPED;
                  end else begin
                     bump.en      = 1'b1;
                     bump.sel     = CNT_PUBLISHED;
                     bump.amount  = LEN_BITS'(1);
                     cache_we     = 1'b1;
                     cvalid_in[t] = 1'b1;
                     u_in         = '0;
                     qcnt_in      = '0;
                     state_in     = ST_PUB_RD;
                  end
               end
               CMD_SUBSCRIBE: begin
                  if (stopped) begin
                     res_in.status = RS_STOPPED;
                  end else if (!known) begin
                     res_in.status = RS_BAD_SUB;
                  end else begin
                     cell_re  = 1'b1;
                     cache_re = 1'b1;
                     state_in = ST_SUB_CHK;
                  end
               end
               CMD_GRANT: begin
                  if (!known) begin
                     res_in.status = RS_BAD_SUB;
                  end else begin
                     cell_re  = 1'b1;
                     state_in = ST_GRANT_WR;
                  end
               end
               CMD_REVOKE: begin
                  if (!known) begin
                     res_in.status = RS_BAD_SUB;
                  end else begin
                     cell_re  = 1'b1;
                     state_in = ST_REV_WR;
                  end
               end
               CMD_DRAIN: begin
                  if (!known) begin
                     res_in.status = RS_BAD_SUB;
                  end else begin
                     idx_in   = '0;
                     k_in     = '0;
                     state_in = ST_DR_RD;
                  end
               end
               CMD_ADD_SUB: begin
                  if (scount_ff >= CNT_FIELD'(SUBSCRIBERS)) begin
                     res_in.status = RS_FULL;
                  end else begin
                     res_in.out_subscriber = scount_ff[SUB_BITS-1:0];
                     scount_in             = scount_ff + 1'b1;
                  end
               end
               CMD_READ_CNT: begin
                  res_in.count_value = stat_value;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_PUB_RD: begin
            cell_re    = 1'b1;
            cell_raddr = {u_ff, t};
            state_in   = ST_PUB_CHK;
         end
         ST_PUB_CHK: begin
            state_in = ST_PUB_NEXT;
            if (cell_rdata.roster) begin
               cell_we               = 1'b1;
               cell_waddr            = {u_ff, t};
               cell_wdata.slot_valid = 1'b1;
               cell_wdata.value      = req_ff.payload;
               qcnt_in               = qcnt_ff + 1'b1;
               pl_in                 = u_ff;
               idx_in                = '0;
               ret_in                = ST_PUB_NEXT;
               state_in              = cell_rdata.slot_valid ? ST_SRCH_RD : ST_APPEND;
            end
         end
         ST_PUB_NEXT: begin
            if (u_ff == SUB_BITS'(SUBSCRIBERS - 1)) begin
               bump.en     = 1'b1;
               bump.sel    = CNT_QUEUED;
               bump.amount = LEN_BITS'(qcnt_ff);
               res_in      = make_res(RS_OK, s, t, '0, '0, 1'b1);
               state_in    = ST_EMIT;
            end else begin
               u_in     = u_ff + 1'b1;
               state_in = ST_PUB_RD;
            end
         end
         ST_SRCH_RD: begin
            // look for the topic in the subscriber's pending list
            if (idx_ff == len_ff[pl_ff]) begin
               state_in = ST_APPEND;
            end else begin
               order_re    = 1'b1;
               order_raddr = {pl_ff, idx_ff[TOPIC_BITS-1:0]};
               state_in    = ST_SRCH_CK;
            end
         end
         ST_SRCH_CK: begin
            if (order_rdata == t) begin
               bump.en     = 1'b1;
               bump.sel    = CNT_CONFLATED;
               bump.amount = LEN_BITS'(1);
               state_in    = ret_ff;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_APPEND: begin
            if (!len_ff[pl_ff][LEN_BITS-1]) begin
               order_we      = 1'b1;
               order_waddr   = {pl_ff, len_ff[pl_ff][TOPIC_BITS-1:0]};
               order_wdata   = t;
               len_in[pl_ff] = len_ff[pl_ff] + 1'b1;
            end
            state_in = ret_ff;
         end
         ST_SUB_CHK: begin
            if (!(open_mode || cell_rdata.entitled)) begin
               bump.en     = 1'b1;
               bump.sel    = CNT_DENIED;
               bump.amount = LEN_BITS'(1);
               res_in      = make_res(RS_DENIED, s, t, '0, '0, 1'b1);
               state_in    = ST_EMIT;
            end else begin
               cell_we           = 1'b1;
               cell_wdata.roster = 1'b1;
               if (cvalid_ff[t]) begin
                  // snapshot of the cached last value
                  cell_wdata.slot_valid = 1'b1;
                  cell_wdata.value      = cache_rdata;
                  pl_in                 = s;
                  idx_in                = '0;
                  ret_in                = ST_SUB_OK;
                  state_in = cell_rdata.slot_valid ? ST_SRCH_RD : ST_APPEND;
               end else begin
                  state_in = ST_SUB_OK;
               end
            end
         end
         ST_SUB_OK: begin
            res_in   = make_res(RS_OK, s, t, '0, '0, 1'b1);
            state_in = ST_EMIT;
         end
         ST_GRANT_WR: begin
            cell_we             = 1'b1;
            cell_wdata.entitled = 1'b1;
            res_in              = make_res(RS_OK, s, t, '0, '0, 1'b1);
            state_in            = ST_EMIT;
         end
         ST_REV_WR: begin
            cell_we               = 1'b1;
            cell_wdata.entitled   = 1'b0;
            cell_wdata.slot_valid = 1'b0;
            bump.en               = 1'b1;
            bump.sel              = CNT_REVOCATIONS;
            bump.amount           = LEN_BITS'(1);
            was_in                = cell_rdata.slot_valid;
            idx_in                = '0;
            j_in                  = '0;
            state_in              = ST_REV_WH;
         end
         ST_REV_WH: begin
            if (was_ff) begin
               bump.en     = 1'b1;
               bump.sel    = CNT_WITHHELD;
               bump.amount = LEN_BITS'(1);
            end
            state_in = ST_REV_RD;
         end
         ST_REV_RD: begin
            if (idx_ff == len_ff[s]) begin
               len_in[s] = j_ff;
               res_in    = make_res(RS_OK, s, t, '0, '0, 1'b1);
               state_in  = ST_EMIT;
            end else begin
               order_re = 1'b1;
               state_in = ST_REV_CK;
            end
         end
         ST_REV_CK: begin
            // compact the list in place, dropping the revoked topic
            if (order_rdata != t) begin
               order_we = 1'b1;
               j_in     = j_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_REV_RD;
         end
         ST_DR_RD: begin
            if (idx_ff == len_ff[s]) begin
               state_in = ST_DR_END;
            end else begin
               order_re = 1'b1;
               state_in = ST_DR_CELL;
            end
         end
         ST_DR_CELL: begin
            v_in       = order_rdata;
            cell_re    = 1'b1;
            cell_raddr = {s, order_rdata};
            state_in   = ST_DR_CK;
         end
         ST_DR_CK: begin
            if (!cell_rdata.slot_valid || !cell_rdata.roster) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DR_RD;
            end else if (!(open_mode || cell_rdata.entitled)) begin
               bump.en     = 1'b1;
               bump.sel    = CNT_WITHHELD;
               bump.amount = LEN_BITS'(1);
               idx_in      = idx_ff + 1'b1;
               state_in    = ST_DR_RD;
            end else if (k_ff == '0 || out_free) begin
               // the previous update goes out; the newest waits for the last flag
               if (k_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = hold_ff;
               end
               hold_in  = make_res(RS_UPDATE, s, v_ff, cell_rdata.value, '0, 1'b0);
               k_in     = k_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DR_RD;
            end
         end
         ST_DR_END: begin
            len_in[s]   = '0;
            bump.en     = 1'b1;
            bump.sel    = CNT_DELIVERED;
            bump.amount = k_ff;
            if (k_ff == '0) begin
               res_in = make_res(RS_OK, s, t, '0, '0, 1'b1);
            end else begin
               res_in             = hold_ff;
               res_in.count_value = COUNTER_BITS'(k_ff);
               res_in.last        = 1'b1;
            end
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scount_ff    <= '0;
         cvalid_ff    <= '0;
         clr_ff       <= '0;
         for (int i = 0; i < SUBSCRIBERS; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         scount_ff    <= scount_in;
         cvalid_ff    <= cvalid_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
      end
      req_ff  <= req_in;
      res_ff  <= res_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
      u_ff    <= u_in;
      pl_ff   <= pl_in;
      qcnt_ff <= qcnt_in;
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      was_ff  <= was_in;
      v_ff    <= v_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== hdl/cft_checker.sv =====
// port-level checks for the conflating fan-out table, bound to the top level
// depends on cft_pkg
module cft_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cft_pkg::rsp_type rsp_word
);
   import cft_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while a command is at work");

   // only delivered updates may leave a command open
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> rsp_word.status == RS_UPDATE
                                      && rsp_word.count_value == '0)
      else $error("non-final word is not a plain update");

   a_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != RS_UPDATE |-> rsp_word.out_payload == '0)
      else $error("payload on a status word");

endmodule

bind conflating_fanout_table cft_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ===== dv/testbench.sv =====
// testbench for the conflating fan-out table: random and directed command words
// checked against a scoreboard that keeps its own copy of the table; needs cft_pkg
module testbench;
   import cft_pkg::*;

   localparam logic [COUNTER_BITS-1:0] CNT_TOP = '1;
   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   class cft_scoreboard;
      bit                    open_mode = 1;
      bit                    stopped   = 0;
      logic [PAYLOAD_BITS-1:0] last_value [TOPICS];
      bit                    last_known [TOPICS];
      logic [PAYLOAD_BITS-1:0] slot_val [SUBSCRIBERS][TOPICS];
      bit                    slot_ok    [SUBSCRIBERS][TOPICS];
      bit                    granted    [SUBSCRIBERS][TOPICS];
      bit                    joined     [SUBSCRIBERS][TOPICS];
      logic [TOPIC_BITS-1:0] queue_order [SUBSCRIBERS][TOPICS];
      int                    queue_len  [SUBSCRIBERS];
      int                    sub_total;
      logic [COUNTER_BITS-1:0] stats [NUM_COUNTERS];
      rsp_type               awaited [$];
      int                    failures;
      int                    words_seen;
      int                    words_checked;

      function new();
         foreach (last_known[t]) last_known[t] = 0;
         foreach (slot_ok[s, t]) begin
            slot_ok[s][t] = 0;
            granted[s][t] = 0;
            joined[s][t]  = 0;
         end
         foreach (queue_len[s]) queue_len[s] = 0;
         foreach (stats[i]) stats[i] = '0;
         sub_total = 0;
         failures  = 0;
         words_seen = 0;
         words_checked = 0;
      endfunction

      function void bump(cnt_sel_type which, int amount);
         logic [COUNTER_BITS:0] sum;
         sum = {1'b0, stats[which]} + (COUNTER_BITS+1)'(amount);
         stats[which] = sum[COUNTER_BITS] ? CNT_TOP : sum[COUNTER_BITS-1:0];
      endfunction

      function void post(res_status_type st, int s, int t, logic [PAYLOAD_BITS-1:0] pay,
                         logic [COUNTER_BITS-1:0] cnt, bit fin);
         rsp_type r;
         r.status         = st;
         r.out_subscriber = SUB_BITS'(s);
         r.out_topic      = TOPIC_BITS'(t);
         r.out_payload    = pay;
         r.count_value    = cnt;
         r.last           = fin;
         awaited = {awaited, r};
      endfunction

      function bit allowed(int s, int t);
         return open_mode || granted[s][t];
      endfunction

      // write a slot; an already pending slot is conflated instead of requeued
      function void slot_in(int s, int t, logic [PAYLOAD_BITS-1:0] v);
         bit queued;
         queued = 0;
         if (slot_ok[s][t])
            for (int i = 0; i < queue_len[s]; i++)
               if (queue_order[s][i] == t) queued = 1;
         slot_val[s][t] = v;
         slot_ok[s][t]  = 1;
         if (queued) bump(CNT_CONFLATED, 1);
         else if (queue_len[s] < TOPICS) begin
            queue_order[s][queue_len[s]] = TOPIC_BITS'(t);
            queue_len[s]++;
         end
      endfunction

      function void note_word(req_type w);
         int s, t, n, k, j;
         bit known;
         s = int'(w.subscriber);
         t = int'(w.topic);
         known = s < sub_total;
         words_seen++;
         case (cmd_type'(w.command))
            CMD_PUBLISH: begin
               if (stopped) post(RS_STOPPED, s, t, 0, 0, 1);
               else begin
                  bump(CNT_PUBLISHED, 1);
                  last_value[t] = w.payload;
                  last_known[t] = 1;
                  n = 0;
                  for (int u = 0; u < SUBSCRIBERS; u++)
                     if (joined[u][t]) begin
                        slot_in(u, t, w.payload);
                        n++;
                     end
                  bump(CNT_QUEUED, n);
                  post(RS_OK, s, t, 0, 0, 1);
               end
            end
            CMD_SUBSCRIBE: begin
               if (stopped) post(RS_STOPPED, s, t, 0, 0, 1);
               else if (!known) post(RS_BAD_SUB, s, t, 0, 0, 1);
               else if (!allowed(s, t)) begin
                  bump(CNT_DENIED, 1);
                  post(RS_DENIED, s, t, 0, 0, 1);
               end else begin
                  joined[s][t] = 1;
                  if (last_known[t]) slot_in(s, t, last_value[t]);
                  post(RS_OK, s, t, 0, 0, 1);
               end
            end
            CMD_GRANT: begin
               if (!known) post(RS_BAD_SUB, s, t, 0, 0, 1);
               else begin
                  granted[s][t] = 1;
                  post(RS_OK, s, t, 0, 0, 1);
               end
            end
            CMD_REVOKE: begin
               if (!known) post(RS_BAD_SUB, s, t, 0, 0, 1);
               else begin
                  granted[s][t] = 0;
                  bump(CNT_REVOCATIONS, 1);
                  if (slot_ok[s][t]) begin
                     slot_ok[s][t] = 0;
                     bump(CNT_WITHHELD, 1);
                  end
                  j = 0;
                  for (int i = 0; i < queue_len[s]; i++)
                     if (queue_order[s][i] != t) begin
                        queue_order[s][j] = queue_order[s][i];
                        j++;
                     end
                  queue_len[s] = j;
                  post(RS_OK, s, t, 0, 0, 1);
               end
            end
            CMD_DRAIN: begin
               if (!known) post(RS_BAD_SUB, s, t, 0, 0, 1);
               else begin
                  k = 0;
                  for (int i = 0; i < queue_len[s]; i++) begin
                     int v;
                     v = int'(queue_order[s][i]);
                     if (slot_ok[s][v] && joined[s][v]) begin
                        if (!allowed(s, v)) bump(CNT_WITHHELD, 1);
                        else begin
                           post(RS_UPDATE, s, v, slot_val[s][v], 0, 0);
                           k++;
                        end
                     end
                  end
                  queue_len[s] = 0;
                  bump(CNT_DELIVERED, k);
                  if (k == 0) post(RS_OK, s, t, 0, 0, 1);
                  else begin
                     awaited[$].count_value = COUNTER_BITS'(k);
                     awaited[$].last = 1;
                  end
               end
            end
            CMD_ADD_SUB: begin
               if (sub_total >= SUBSCRIBERS) post(RS_FULL, s, t, 0, 0, 1);
               else begin
                  post(RS_OK, sub_total, t, 0, 0, 1);
                  sub_total++;
               end
            end
            CMD_READ_CNT:
               post(RS_OK, s, t, 0,
                    w.counter_select < NUM_COUNTERS ? stats[w.counter_select] : '0, 1);
            default: ;
         endcase
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         words_checked++;
         if (awaited.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.out_subscriber !== want.out_subscriber) begin
            $error("out_subscriber: expected %0d, got %0d",
                   want.out_subscriber, got.out_subscriber);
            failures++;
         end
         if (got.out_topic !== want.out_topic) begin
            $error("out_topic: expected %0d, got %0d", want.out_topic, got.out_topic);
            failures++;
         end
         if (got.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload, got.out_payload);
            failures++;
         end
         if (got.count_value !== want.count_value) begin
            $error("count_value: expected %0d, got %0d", want.count_value, got.count_value);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_word;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cft_scoreboard sb = new();
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet = 0;

   conflating_fanout_table i_dut (.*);

   always #2 clock = ~clock;

   // result side: take words, then pick next cycle's stall
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) sb.check_word(rsp_word);
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send(req_type w);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   task automatic cmd(cmd_type c, int s, int t, logic [PAYLOAD_BITS-1:0] pay = 0, int sel = 0);
      req_type w;
      w.command = c;
      w.subscriber = SUB_BITS'(s);
      w.topic = TOPIC_BITS'(t);
      w.payload = pay;
      w.counter_select = 3'(sel);
      send(w);
   endtask

   // let everything drain before touching the registers
   task automatic settle();
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(csr_reg_type r, bit v);
      csr_psel   <= 1;
      csr_pwrite <= 1;
      csr_paddr  <= CSR_ADDR_BITS'(4 * r);
      csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      if (r == REG_OPEN) sb.open_mode = v;
      else sb.stopped = v;
   endtask

   task automatic random_word();
      req_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.command = pick < 30 ? CMD_PUBLISH : pick < 50 ? CMD_SUBSCRIBE :
                  pick < 60 ? CMD_GRANT : pick < 68 ? CMD_REVOKE :
                  pick < 88 ? CMD_DRAIN : pick < 90 ? CMD_ADD_SUB :
                  pick < 98 ? CMD_READ_CNT : CMD_NONE;
      w.subscriber = SUB_BITS'($urandom_range(0, SUBSCRIBERS - 1));
      // a few hot topics so slots conflate and lists repeat
      w.topic = TOPIC_BITS'($urandom_range(0, 3) != 0 ? $urandom_range(0, 7)
                                                       : $urandom_range(0, TOPICS - 1));
      w.payload = $urandom;
      w.counter_select = 3'($urandom_range(0, 7));
      send(w);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // unknown subscribers, then fill the table past its size
      cmd(CMD_SUBSCRIBE, 0, 1);
      cmd(CMD_GRANT, 7, 2);
      cmd(CMD_REVOKE, 3, 3);
      cmd(CMD_DRAIN, 0, 4);
      for (int i = 0; i <= SUBSCRIBERS; i++) cmd(CMD_ADD_SUB, 7 - (i % 8), i);
      cmd(CMD_PUBLISH, 5, 63, 32'hffff_ffff);
      cmd(CMD_PUBLISH, 2, 0, 32'h0);
      cmd(CMD_SUBSCRIBE, 0, 63);
      cmd(CMD_SUBSCRIBE, 7, 0);
      cmd(CMD_PUBLISH, 1, 63, 32'h5);
      cmd(CMD_DRAIN, 0, 9);
      cmd(CMD_DRAIN, 7, 0);
      cmd(CMD_DRAIN, 1, 0);
      cmd(CMD_REVOKE, 0, 63);
      cmd(CMD_NONE, 4, 12);
      for (int i = 0; i < 8; i++) cmd(CMD_READ_CNT, i, i, 0, i);
      settle();

      // checked grants: denied, then granted and delivered; then the stopped state
      csr_write(REG_OPEN, 0);
      cmd(CMD_SUBSCRIBE, 1, 5);
      cmd(CMD_GRANT, 1, 5);
      cmd(CMD_SUBSCRIBE, 1, 5);
      cmd(CMD_PUBLISH, 0, 5, 32'h1234_5678);
      cmd(CMD_DRAIN, 1, 5);
      settle();
      csr_write(REG_STOP, 1);
      cmd(CMD_PUBLISH, 3, 5, 32'hdead_beef);
      cmd(CMD_SUBSCRIBE, 1, 6);
      cmd(CMD_DRAIN, 1, 5);
      settle();
      csr_write(REG_STOP, 0);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = phase == 0 ? 12 : phase == 1 ? 53 : 0;
         rsp_idle_pct = phase == 0 ? 53 : phase == 1 ? 12 : 0;
         settle();
         csr_write(REG_OPEN, phase != 1);
         if (phase == 2) hold_request = 1;
         repeat (125) random_word();
      end
      settle();
      csr_write(REG_STOP, 1);
      repeat (15) random_word();
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("%0d command words sent and %0d result words checked over three idling phases,",
               sb.words_seen, sb.words_checked);
      $display("open and checked grant modes, a stopped phase and a long result hold-off");
      if (sb.failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
